/* sv/trl_pkg.sv */
// shared types and constants for the transpose ranking list
`default_nettype none

package trl_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DEF_KEY_BITS = 32;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned RANK_W  = 5;
  localparam int unsigned PLACE_W = 5;
  localparam int unsigned COUNT_W = 5;

  // key, rank packed and padded to bytes
  localparam int unsigned IN_DATA_W  = 40;
  // item, place, count packed and padded to bytes
  localparam int unsigned OUT_PAD    = 6;
  localparam int unsigned OUT_DATA_W = KEY_W + PLACE_W + COUNT_W + OUT_PAD;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 3'd0,
    FN_GET      = 3'd1,
    FN_CONTAINS = 3'd2,
    FN_DOWN     = 3'd3,
    FN_POSITION = 3'd4,
    FN_TOP      = 3'd5
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PAIR0,
    ST_PAIR1,
    ST_PAIR2,
    ST_W1,
    ST_W2,
    ST_RESP,
    ST_TOP_RD,
    ST_TOP_OUT
  } state_e;

endpackage

`default_nettype wire

/* sv/transpose_ranking_list_core.sv */
// self-organizing key list with transpose reordering, keys kept in one ram
//
//  channel   dir  tdata (low bit up)                  tuser  tlast
//  s_axis    in   key[31:0], rank[36:32], pad         func   -
//  m_axis    out  item[31:0], place[36:32],           ok     last of item
//                 count[41:37], pad
//
// add, contains, position: the key scan reads one entry per cycle and checks it in
// the next cycle; add and contains then make 2 ram writes when the key moves up,
// then the result is handed off and the core idles before taking the next.
// get and down: read a pair (pair0, pair1, pair2), write it back swapped (w1, w2),
// hand off the result and idle; get of rank one stops after pair1, writing nothing.
// top k: each key is read in top_rd, handed off in top_out, held while m_axis stalls.
// reset clears state, fill and valid flags; entries at or past fill are unused.
// one result register sits on m_axis, a new beat is taken while it waits.
`default_nettype none

module transpose_ranking_list_core #(
  parameter int unsigned CAPACITY = trl_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_BITS = trl_pkg::DEF_KEY_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [trl_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // key, rank
  input  wire logic [trl_pkg::FUNC_W-1:0]      s_axis_tuser,  // func
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [trl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // item, place, count
  output logic                                 m_axis_tuser,  // ok
  output logic                                 m_axis_tlast
);

  import trl_pkg::*;

  localparam int unsigned SW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned NW = (CW > RANK_W) ? CW : RANK_W;

  state_e              state_q, state_d;
  func_e               func_q, func_d;
  logic [SW-1:0]       key_q, key_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic                chk_valid_q, chk_valid_d;
  logic [AW-1:0]       chk_idx_q, chk_idx_d;
  logic [SW-1:0]       prev_q, prev_d;
  logic [SW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       wa_q, wa_d;
  logic                single_q, single_d;
  logic [CW-1:0]       top_m_q, top_m_d;
  logic                res_ok_q, res_ok_d;
  logic [SW-1:0]       res_item_q, res_item_d;
  logic [PLACE_W-1:0]  res_place_q, res_place_d;

  logic                out_valid_q, out_valid_d;
  logic                out_ok_q, out_ok_d;
  logic [KEY_W-1:0]    out_item_q, out_item_d;
  logic [PLACE_W-1:0]  out_place_q, out_place_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_last_q, out_last_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SW-1:0]       ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SW-1:0]       ram_rdata;

  logic [RANK_W-1:0]   in_n;
  logic [NW-1:0]       n_w;
  logic [NW-1:0]       fill_w;
  logic                out_free;
  logic                out_load;
  logic                load_ok;
  logic [SW-1:0]       load_item;
  logic [PLACE_W-1:0]  load_place;
  logic                load_last;

  trl_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_n     = s_axis_tdata[KEY_W +: RANK_W];
  assign n_w      = NW'(in_n);
  assign fill_w   = NW'(fill_q);
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    key_d       = key_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    chk_valid_d = 1'b0;
    chk_idx_d   = chk_idx_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    wa_d        = wa_q;
    single_d    = single_q;
    top_m_d     = top_m_q;
    res_ok_d    = res_ok_q;
    res_item_d  = res_item_q;
    res_place_d = res_place_q;
    ram_we      = 1'b0;
    ram_waddr   = wa_q;
    ram_wdata   = cur_q;
    ram_re      = 1'b0;
    ram_raddr   = wa_q;
    out_load    = 1'b0;
    load_ok     = res_ok_q;
    load_item   = res_item_q;
    load_place  = res_place_q;
    load_last   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_d      = func_e'(s_axis_tuser);
          key_d       = SW'(s_axis_tdata[KEY_W-1:0]);
          rd_idx_d    = '0;
          res_ok_d    = 1'b0;
          res_item_d  = '0;
          res_place_d = '0;
          single_d    = 1'b0;
          priority case (func_e'(s_axis_tuser))
            FN_ADD, FN_CONTAINS, FN_POSITION: begin
              state_d = ST_SCAN;
            end
            FN_GET: begin
              if (n_w == '0 || n_w > fill_w) begin
                state_d = ST_RESP;
              end else begin
                single_d = (n_w == NW'(1));
                wa_d     = (n_w == NW'(1)) ? '0 : AW'(n_w - NW'(2));
                state_d  = ST_PAIR0;
              end
            end
            FN_DOWN: begin
              if (n_w != '0 && n_w < fill_w) begin
                wa_d    = AW'(n_w - NW'(1));
                state_d = ST_PAIR0;
              end else begin
                state_d = ST_RESP;
              end
            end
            FN_TOP: begin
              top_m_d = CW'((n_w < fill_w) ? n_w : fill_w);
              state_d = (n_w == '0 || fill_q == '0) ? ST_RESP : ST_TOP_RD;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        ram_re      = (rd_idx_q < fill_q);
        ram_raddr   = rd_idx_q[AW-1:0];
        rd_idx_d    = rd_idx_q + CW'(1);
        chk_valid_d = ram_re;
        chk_idx_d   = rd_idx_q[AW-1:0];
        if (chk_valid_q) begin
          if (ram_rdata == key_q) begin
            // hit: prev_q holds the entry one rank ahead
            res_ok_d = 1'b1;
            wa_d     = AW'(chk_idx_q - AW'(1));
            cur_d    = ram_rdata;
            priority case (func_q)
              FN_ADD:      res_place_d = (chk_idx_q == '0) ? PLACE_W'(1)
                                                           : PLACE_W'(chk_idx_q);
              FN_POSITION: res_place_d = PLACE_W'(CW'(chk_idx_q) + CW'(1));
              default:     res_place_d = '0;
            endcase
            state_d = (chk_idx_q != '0 && func_q != FN_POSITION) ? ST_W1 : ST_RESP;
          end else if (CW'(chk_idx_q) == fill_q - CW'(1)) begin
            state_d = ST_RESP;
            if (func_q == FN_ADD && fill_q < CW'(CAPACITY)) begin
              ram_we      = 1'b1;
              ram_waddr   = fill_q[AW-1:0];
              ram_wdata   = key_q;
              fill_d      = fill_q + CW'(1);
              res_ok_d    = 1'b1;
              res_place_d = PLACE_W'(fill_q + CW'(1));
            end
          end else begin
            prev_d = ram_rdata;
          end
        end else if (fill_q == '0) begin
          // empty list: nothing to scan
          state_d = ST_RESP;
          if (func_q == FN_ADD) begin
            ram_we      = 1'b1;
            ram_waddr   = '0;
            ram_wdata   = key_q;
            fill_d      = CW'(1);
            res_ok_d    = 1'b1;
            res_place_d = PLACE_W'(1);
          end
        end
      end

      ST_PAIR0: begin
        ram_re    = 1'b1;
        ram_raddr = wa_q;
        state_d   = ST_PAIR1;
      end

      ST_PAIR1: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(wa_q + AW'(1));
        prev_d    = ram_rdata;
        if (single_q) begin
          res_ok_d   = 1'b1;
          res_item_d = ram_rdata;
          state_d    = ST_RESP;
        end else begin
          state_d = ST_PAIR2;
        end
      end

      ST_PAIR2: begin
        cur_d    = ram_rdata;
        res_ok_d = 1'b1;
        if (func_q == FN_GET) begin
          res_item_d = ram_rdata;
        end
        state_d = ST_W1;
      end

      ST_W1: begin
        ram_we    = 1'b1;
        ram_waddr = wa_q;
        ram_wdata = cur_q;
        state_d   = ST_W2;
      end

      ST_W2: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(wa_q + AW'(1));
        ram_wdata = prev_q;
        state_d   = ST_RESP;
      end

      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_TOP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rd_idx_q[AW-1:0];
        state_d   = ST_TOP_OUT;
      end

      ST_TOP_OUT: begin
        load_ok    = 1'b1;
        load_item  = ram_rdata;
        load_place = '0;
        load_last  = (rd_idx_q + CW'(1) == top_m_q);
        if (out_free) begin
          out_load = 1'b1;
          rd_idx_d = rd_idx_q + CW'(1);
          state_d  = load_last ? ST_IDLE : ST_TOP_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ok_d    = out_ok_q;
    out_item_d  = out_item_q;
    out_place_d = out_place_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_ok_d    = load_ok;
      out_item_d  = KEY_W'(load_item);
      out_place_d = load_place;
      out_count_d = COUNT_W'(fill_q);
      out_last_d  = load_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    key_q       <= key_d;
    rd_idx_q    <= rd_idx_d;
    chk_idx_q   <= chk_idx_d;
    prev_q      <= prev_d;
    cur_q       <= cur_d;
    wa_q        <= wa_d;
    single_q    <= single_d;
    top_m_q     <= top_m_d;
    res_ok_q    <= res_ok_d;
    res_item_q  <= res_item_d;
    res_place_q <= res_place_d;
    out_ok_q    <= out_ok_d;
    out_item_q  <= out_item_d;
    out_place_q <= out_place_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_count_q, out_place_q, out_item_q};
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tlast  = out_last_q;

  // the list never holds more keys than it has room for
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  // the count only grows, one key at a time
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + CW'(1)))
    else $error("fill count changed by other than one");

  // no ram write outside a command in progress
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("ram written while idle");

  // a result is loaded only when the output register can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* sv/trl_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module trl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* verif/tb_transpose_ranking_list_core.sv */
// self-checking testbench for the transpose ranking list core
`default_nettype none

module tb_transpose_ranking_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  import trl_pkg::*;

  localparam int unsigned CAP          = DEF_CAPACITY;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned DRAIN_CYCLES = 2 * CAP + 16;
  localparam int unsigned MAX_PRINTS   = 40;

  // func codes outside the enum, answered with a plain refusal
  localparam logic [FUNC_W-1:0] FN_BAD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_BAD7 = 3'd7;

  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   item;
    logic [PLACE_W-1:0] place;
    logic [COUNT_W-1:0] count;
    logic               last;
  } beat_t;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
    int unsigned       reps;
    bit                typed;
    beat_t             exp;
  } row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // key, rank, pad
  logic [FUNC_W-1:0]     s_axis_tuser  = '0;  // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // item, place, count, pad
  logic                  m_axis_tuser;        // ok
  logic                  m_axis_tlast;

  transpose_ranking_list_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5ns clk_i = ~clk_i;

  // shadow copy of the ranked list
  logic [KEY_W-1:0] list_keys [CAP];
  int unsigned      list_fill = 0;
  beat_t            expected_beats [$];
  int unsigned      fail_count = 0;
  int unsigned      burst_left = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  row_t             directed_rows [$];

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic int find_key(input logic [KEY_W-1:0] k);
    for (int i = 0; i < int'(list_fill); i++) begin
      if (list_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void swap_toward_front(input int idx);
    logic [KEY_W-1:0] t;
    t                = list_keys[idx-1];
    list_keys[idx-1] = list_keys[idx];
    list_keys[idx]   = t;
  endfunction

  function automatic void push_beat(input logic ok, input logic [KEY_W-1:0] item,
                                    input int place, input logic last);
    beat_t b;
    b.ok    = ok;
    b.item  = item;
    b.place = PLACE_W'(place);
    b.count = COUNT_W'(list_fill);
    b.last  = last;
    expected_beats.push_back(b);
  endfunction

  // applies one operation to the shadow list and queues the beats it yields
  function automatic void apply_list_op(input logic [FUNC_W-1:0] fn,
                                        input logic [KEY_W-1:0] key,
                                        input logic [RANK_W-1:0] rank);
    int pos;
    int n;
    int m;
    logic [KEY_W-1:0] v;
    n   = int'(rank);
    pos = find_key(key);
    case (fn)
      FN_ADD: begin
        if (pos > 0) begin
          swap_toward_front(pos);
          push_beat(1'b1, '0, pos, 1'b1);
        end else if (pos == 0) begin
          push_beat(1'b1, '0, 1, 1'b1);
        end else if (list_fill >= CAP) begin
          push_beat(1'b0, '0, 0, 1'b1);
        end else begin
          list_keys[list_fill] = key;
          list_fill++;
          push_beat(1'b1, '0, int'(list_fill), 1'b1);
        end
      end
      FN_GET: begin
        if (n == 0 || n > int'(list_fill)) begin
          push_beat(1'b0, '0, 0, 1'b1);
        end else begin
          v = list_keys[n-1];
          if (n > 1) swap_toward_front(n - 1);
          push_beat(1'b1, v, 0, 1'b1);
        end
      end
      FN_CONTAINS: begin
        if (pos > 0) swap_toward_front(pos);
        push_beat(pos >= 0, '0, 0, 1'b1);
      end
      FN_DOWN: begin
        if (n > 0 && n < int'(list_fill)) begin
          swap_toward_front(n);
          push_beat(1'b1, '0, 0, 1'b1);
        end else begin
          push_beat(1'b0, '0, 0, 1'b1);
        end
      end
      FN_POSITION: begin
        if (pos >= 0) push_beat(1'b1, '0, pos + 1, 1'b1);
        else push_beat(1'b0, '0, 0, 1'b1);
      end
      FN_TOP: begin
        m = (n < int'(list_fill)) ? n : int'(list_fill);
        if (m == 0) begin
          push_beat(1'b0, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < m; i++) push_beat(1'b1, list_keys[i], 0, i + 1 == m);
        end
      end
      default: begin
        push_beat(1'b0, '0, 0, 1'b1);
      end
    endcase
  endfunction

  // drives one beat, holds it until taken, then paces the next burst
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                           input logic [RANK_W-1:0] rank, input bit typed,
                           input beat_t exp);
    int unsigned depth;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - KEY_W - RANK_W){1'b0}}, rank, key};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    depth = expected_beats.size();
    apply_list_op(fn, key, rank);
    if (typed) begin
      while (expected_beats.size() > depth) void'(expected_beats.pop_back());
      expected_beats.push_back(exp);
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // sender holds off until every queued beat has come back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // receiver stall pattern: phases of always ready, light, heavy and long stalls
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (stall_left % 12) == 0;
    endcase
  end

  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ok    = m_axis_tuser;
      got.item  = m_axis_tdata[KEY_W-1:0];
      got.place = m_axis_tdata[KEY_W +: PLACE_W];
      got.count = m_axis_tdata[KEY_W+PLACE_W +: COUNT_W];
      got.last  = m_axis_tlast;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %p", got));
      end else begin
        want = expected_beats.pop_front();
        if (got.ok !== want.ok)
          report_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
        if (got.item !== want.item)
          report_mismatch($sformatf("item %h, want %h", got.item, want.item));
        if (got.place !== want.place)
          report_mismatch($sformatf("place %0d, want %0d", got.place, want.place));
        if (got.count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      end
    end
  end

  initial begin
    #8ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    row_t             row;
    logic [FUNC_W-1:0] fn;
    logic [KEY_W-1:0] key;
    logic [RANK_W-1:0] rank;
    int unsigned      pick;

    // empty list refusals, appends and moves, then a full list
    directed_rows.push_back('{FN_TOP,      32'h0,         5'd5,  1, 1'b1, '{0, 0, 0, 0, 1}});
    directed_rows.push_back('{FN_GET,      32'h0,         5'd1,  1, 1'b1, '{0, 0, 0, 0, 1}});
    directed_rows.push_back('{FN_CONTAINS, 32'h0,         5'd0,  1, 1'b1, '{0, 0, 0, 0, 1}});
    directed_rows.push_back('{FN_BAD7,     32'hFFFFFFFF,  5'd31, 1, 1'b1, '{0, 0, 0, 0, 1}});
    directed_rows.push_back('{FN_ADD,      32'h0,         5'd0,  1, 1'b1, '{1, 0, 1, 1, 1}});
    directed_rows.push_back('{FN_ADD,      32'hFFFFFFFF,  5'd0,  1, 1'b1, '{1, 0, 2, 2, 1}});
    directed_rows.push_back('{FN_ADD,      32'hFFFFFFFF,  5'd0,  1, 1'b1, '{1, 0, 1, 2, 1}});
    directed_rows.push_back('{FN_ADD,      32'hFFFFFFFF,  5'd0,  1, 1'b1, '{1, 0, 1, 2, 1}});
    directed_rows.push_back('{FN_ADD,      32'hA5A50002,  5'd0,  14, 1'b0, '0});
    directed_rows.push_back('{FN_ADD,      32'h12345678,  5'd0,  1, 1'b1, '{0, 0, 0, 16, 1}});
    directed_rows.push_back('{FN_GET,      32'h0,         5'd16, 1, 1'b0, '0});
    directed_rows.push_back('{FN_GET,      32'h0,         5'd17, 1, 1'b1, '{0, 0, 0, 16, 1}});
    directed_rows.push_back('{FN_GET,      32'h0,         5'd0,  1, 1'b1, '{0, 0, 0, 16, 1}});
    directed_rows.push_back('{FN_DOWN,     32'h0,         5'd16, 1, 1'b1, '{0, 0, 0, 16, 1}});
    directed_rows.push_back('{FN_DOWN,     32'h0,         5'd1,  1, 1'b0, '0});
    directed_rows.push_back('{FN_CONTAINS, 32'h0,         5'd0,  1, 1'b0, '0});
    directed_rows.push_back('{FN_POSITION, 32'h0,         5'd0,  1, 1'b0, '0});
    directed_rows.push_back('{FN_TOP,      32'h0,         5'd31, 1, 1'b0, '0});
    directed_rows.push_back('{FN_TOP,      32'h0,         5'd0,  1, 1'b1, '{0, 0, 0, 16, 1}});
    directed_rows.push_back('{FN_BAD6,     32'h0,         5'd0,  1, 1'b1, '{0, 0, 0, 16, 1}});
    directed_rows.push_back('{FN_POSITION, 32'h12345678,  5'd0,  1, 1'b1, '{0, 0, 0, 16, 1}});
    directed_rows.push_back('{FN_DOWN,     32'h0,         5'd15, 1, 1'b0, '0});

    // pool mixes keys already held with fresh ones, more keys than places
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFFFFFF;
    for (int i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = (i < 12) ? 32'hA5A50000 + i : $urandom();
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int k = 0; k < int'(row.reps); k++) begin
        send_item(row.fn, row.key + k, row.rank, row.typed, row.exp);
      end
    end
    wait_for_results();

    for (int i = 0; i < int'(RANDOM_ITEMS); i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) fn = FN_ADD;
      else if (pick < 44) fn = FN_GET;
      else if (pick < 56) fn = FN_CONTAINS;
      else if (pick < 68) fn = FN_DOWN;
      else if (pick < 80) fn = FN_POSITION;
      else if (pick < 94) fn = FN_TOP;
      else if (pick < 97) fn = FN_BAD6;
      else fn = FN_BAD7;
      key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : $urandom();
      rank = ($urandom_range(0, 99) < 80) ? RANK_W'($urandom_range(1, list_fill + 1))
                                           : RANK_W'($urandom_range(0, 31));
      send_item(fn, key, rank, 1'b0, '0);
      if (i == RANDOM_ITEMS / 2) wait_for_results();
    end
    wait_for_results();

    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* transpose_ranking_list_core.f */
sv/trl_pkg.sv
sv/trl_ram.sv
sv/transpose_ranking_list_core.sv
verif/tb_transpose_ranking_list_core.sv
